[rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define SPQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("spq assertion failed");

// checked at every edge, reset included
`define SPQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("spq reset assertion failed");

`endif

[rtl/spq_pkg.sv]
// types and constants of the stable priority request queue
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int DATA_W      = 8;
  localparam int OCC_W       = 5;

  typedef enum logic {
    FUNC_INSERT  = 1'b0,
    FUNC_PROCESS = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_SERVED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_SERVE,
    OP_REPORT_EMPTY,
    OP_REJECT_FULL
  } op_t;

  typedef enum logic {
    CS_IDLE,
    CS_HOLD
  } ctrl_state_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic q_full;
    logic q_empty;
  } dp_status_t;

endpackage

[rtl/spq_ctrl.sv]
// controller: transaction handshake and operation decode
module spq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_func,
  output logic                out_valid,
  input  logic                out_stall,
  input  spq_pkg::dp_status_t dp_status,
  output spq_pkg::dp_cmd_t    dp_cmd
);

  spq_pkg::ctrl_state_t state_r, state_nxt;
  logic                 accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spq_pkg::CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      spq_pkg::CS_IDLE: begin
        in_stall = 1'b0;
      end
      spq_pkg::CS_HOLD: begin
        out_valid = 1'b1;
        // a result being taken frees the output register this cycle
        in_stall  = out_stall;
        if (!out_stall) begin
          state_nxt = spq_pkg::CS_IDLE;
        end
      end
      default: begin
        state_nxt = spq_pkg::CS_IDLE;
      end
    endcase
    accept = in_valid && !in_stall;
    if (accept) begin
      state_nxt = spq_pkg::CS_HOLD;
    end
  end

  always_comb begin
    dp_cmd.op = spq_pkg::OP_NONE;
    if (accept) begin
      if (in_func == spq_pkg::FUNC_INSERT) begin
        dp_cmd.op = dp_status.q_full ? spq_pkg::OP_REJECT_FULL : spq_pkg::OP_INSERT;
      end else begin
        dp_cmd.op = dp_status.q_empty ? spq_pkg::OP_REPORT_EMPTY : spq_pkg::OP_SERVE;
      end
    end
  end

endmodule

[rtl/spq_datapath.sv]
// datapath: sorted shift-register queue and result register
module spq_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  spq_pkg::dp_cmd_t                  dp_cmd,
  output spq_pkg::dp_status_t               dp_status,
  input  logic [spq_pkg::DATA_W-1:0]        in_device_id,
  input  logic [spq_pkg::DATA_W-1:0]        in_req_priority,
  output logic [1:0]                        out_status,
  output logic [spq_pkg::DATA_W-1:0]        out_served_device,
  output logic [spq_pkg::DATA_W-1:0]        out_served_priority,
  output logic [spq_pkg::OCC_W-1:0]         out_occupancy
);

  logic [spq_pkg::DATA_W-1:0] pri_r [spq_pkg::QUEUE_DEPTH];
  logic [spq_pkg::DATA_W-1:0] dev_r [spq_pkg::QUEUE_DEPTH];
  logic [spq_pkg::DATA_W-1:0] pri_nxt [spq_pkg::QUEUE_DEPTH];
  logic [spq_pkg::DATA_W-1:0] dev_nxt [spq_pkg::QUEUE_DEPTH];
  logic [spq_pkg::QUEUE_DEPTH-1:0] after_ins;
  logic [spq_pkg::CNT_W-1:0]  count_r, count_nxt;

  spq_pkg::status_t           status_r, status_nxt;
  logic [spq_pkg::DATA_W-1:0] sdev_r, sdev_nxt;
  logic [spq_pkg::DATA_W-1:0] spri_r, spri_nxt;
  logic [spq_pkg::OCC_W-1:0]  occ_r;
  logic                       res_load;

  assign dp_status.q_full  = (count_r == spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH));
  assign dp_status.q_empty = (count_r == '0);

  // one comparator per slot: slot sits at or after the insertion point
  always_comb begin
    for (int i = 0; i < spq_pkg::QUEUE_DEPTH; i++) begin
      after_ins[i] = (count_r <= spq_pkg::CNT_W'(i)) || (pri_r[i] > in_req_priority);
    end
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = spq_pkg::ST_INSERTED;
    sdev_nxt   = '0;
    spri_nxt   = '0;
    res_load   = 1'b1;
    for (int i = 0; i < spq_pkg::QUEUE_DEPTH; i++) begin
      pri_nxt[i] = pri_r[i];
      dev_nxt[i] = dev_r[i];
    end
    case (dp_cmd.op)
      spq_pkg::OP_INSERT: begin
        if (after_ins[0]) begin
          pri_nxt[0] = in_req_priority;
          dev_nxt[0] = in_device_id;
        end
        for (int i = 1; i < spq_pkg::QUEUE_DEPTH; i++) begin
          if (after_ins[i]) begin
            if (!after_ins[i-1]) begin
              pri_nxt[i] = in_req_priority;
              dev_nxt[i] = in_device_id;
            end else begin
              pri_nxt[i] = pri_r[i-1];
              dev_nxt[i] = dev_r[i-1];
            end
          end
        end
        count_nxt  = count_r + spq_pkg::CNT_W'(1);
        status_nxt = spq_pkg::ST_INSERTED;
      end
      spq_pkg::OP_SERVE: begin
        for (int i = 0; i < spq_pkg::QUEUE_DEPTH - 1; i++) begin
          pri_nxt[i] = pri_r[i+1];
          dev_nxt[i] = dev_r[i+1];
        end
        count_nxt  = count_r - spq_pkg::CNT_W'(1);
        status_nxt = spq_pkg::ST_SERVED;
        sdev_nxt   = dev_r[0];
        spri_nxt   = pri_r[0];
      end
      spq_pkg::OP_REPORT_EMPTY: begin
        status_nxt = spq_pkg::ST_EMPTY;
      end
      spq_pkg::OP_REJECT_FULL: begin
        status_nxt = spq_pkg::ST_FULL;
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < spq_pkg::QUEUE_DEPTH; i++) begin
      pri_r[i] <= pri_nxt[i];
      dev_r[i] <= dev_nxt[i];
    end
    if (res_load) begin
      status_r <= status_nxt;
      sdev_r   <= sdev_nxt;
      spri_r   <= spri_nxt;
      occ_r    <= spq_pkg::OCC_W'(count_nxt);
    end
  end

  assign out_status          = status_r;
  assign out_served_device   = sdev_r;
  assign out_served_priority = spri_r;
  assign out_occupancy       = occ_r;

endmodule

[rtl/stable_priority_request_queue_unit.sv]
// top level of the stable priority request queue
//
// sorted queue of device requests, 16 entries, lower priority value served
// first, equal priorities leave in arrival order.
// input channel: in_valid / in_stall with in_func (insert or process),
// in_device_id and in_req_priority. output channel: out_valid / out_stall
// with out_status, out_served_device, out_served_priority, out_occupancy.
// every input transaction gives exactly one result transaction.
// latency: the result is valid the cycle after the input is accepted.
// throughput: one transaction per cycle while out_stall is low; the whole
// shift-register queue with one comparator per slot updates in the
// accept cycle. a full queue drops an insert and reports full; processing
// an empty queue reports empty. both leave the queue unchanged.
// while out_stall holds a pending result, in_stall is raised and the
// result stays on the output ports.
// reset (rst_n low, synchronous) empties the queue and clears out_valid.
module stable_priority_request_queue_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_func,
  input  logic [spq_pkg::DATA_W-1:0] in_device_id,
  input  logic [spq_pkg::DATA_W-1:0] in_req_priority,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_status,
  output logic [spq_pkg::DATA_W-1:0] out_served_device,
  output logic [spq_pkg::DATA_W-1:0] out_served_priority,
  output logic [spq_pkg::OCC_W-1:0]  out_occupancy
);

  spq_pkg::dp_cmd_t    dp_cmd;
  spq_pkg::dp_status_t dp_status;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_status (dp_status),
    .dp_cmd    (dp_cmd)
  );

  spq_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .dp_cmd              (dp_cmd),
    .dp_status           (dp_status),
    .in_device_id        (in_device_id),
    .in_req_priority     (in_req_priority),
    .out_status          (out_status),
    .out_served_device   (out_served_device),
    .out_served_priority (out_served_priority),
    .out_occupancy       (out_occupancy)
  );

endmodule

[rtl/spq_checker.sv]
// port-level checker for the stable priority request queue, with its bind
`include "assert_macros.svh"

module spq_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [1:0]                 out_status,
  input logic [spq_pkg::OCC_W-1:0]  out_occupancy
);

  `SPQ_ASSERT(a_out_holds, out_valid && out_stall |=> out_valid)
  `SPQ_ASSERT(a_accept_gives_result, in_valid && !in_stall |=> out_valid)
  `SPQ_ASSERT(a_empty_zero_occ, out_valid && out_status == spq_pkg::ST_EMPTY |-> out_occupancy == '0)
  `SPQ_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid)

endmodule

bind stable_priority_request_queue_unit spq_checker u_spq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_status    (out_status),
  .out_occupancy (out_occupancy)
);
